@@ rtl/trrg_pkg.sv @@
package trrg_pkg;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] REG_POWER_MAX      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TEMP_MIN       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_MAX       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POWER_RATE_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TEMP_RATE_MAX  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WATER_RATE_MAX = 3'd5;

  // Water level 1.0 in Q16
  localparam logic [16:0] WATER_ONE = 17'h10000;

  typedef enum logic [1:0] {
    Q_GOOD    = 2'd0,
    Q_SUSPECT = 2'd1,
    Q_BAD     = 2'd2
  } quality_e;

  typedef struct packed {
    logic [31:0]        timestamp_s;
    logic signed [19:0] power;
    logic signed [15:0] temperature;
    logic signed [17:0] water_level;
    logic               power_ok;
    logic               temp_ok;
    logic               water_ok;
  } frame_t;

  typedef struct packed {
    logic [31:0]        timestamp_s;
    logic signed [19:0] power;
    logic signed [15:0] temperature;
    logic signed [17:0] water_level;
  } prev_t;

  typedef struct packed {
    frame_t cur;
    prev_t  prev;
    logic   have_prev;
  } stage_t;

  typedef struct packed {
    logic [18:0]        power_max;
    logic signed [15:0] temp_min;
    logic signed [15:0] temp_max;
    logic [19:0]        power_rate_max;
    logic [15:0]        temp_rate_max;
    logic [17:0]        water_rate_max;
  } cfg_t;

endpackage

@@ rtl/trrg_in_stage.sv @@
module trrg_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  trrg_pkg::frame_t frame_i,
  input  logic            advance_i,
  output logic            valid_o,
  output trrg_pkg::stage_t stage_o
);
  import trrg_pkg::*;

  logic   s1_valid_q;
  stage_t s1_q;
  prev_t  prev_q;
  logic   have_prev_q;
  logic   accept;

  assign ready_o = !s1_valid_q || advance_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = s1_valid_q;
  assign stage_o = s1_q;

  // Stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= valid_i;
    end
  end

  // Previous-frame history: every accepted frame replaces it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (accept) begin
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q.timestamp_s <= frame_i.timestamp_s;
      prev_q.power       <= frame_i.power;
      prev_q.temperature <= frame_i.temperature;
      prev_q.water_level <= frame_i.water_level;
    end
  end

  // Input register with a snapshot of the history it is judged against
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.cur       <= frame_i;
      s1_q.prev      <= prev_q;
      s1_q.have_prev <= have_prev_q;
    end
  end

endmodule

@@ rtl/trrg_check.sv @@
module trrg_check (
  input  trrg_pkg::stage_t   stage_i,
  input  trrg_pkg::cfg_t     cfg_i,
  output trrg_pkg::quality_e quality_o
);
  import trrg_pkg::*;

  logic        in_range;
  logic        healthy;
  logic [32:0] dt;
  logic        dt_bad;
  logic [20:0] pw_diff;
  logic [16:0] tp_diff;
  logic [18:0] wl_diff;
  logic [20:0] pw_abs;
  logic [16:0] tp_abs;
  logic [18:0] wl_abs;
  logic [51:0] pw_lim;
  logic [47:0] tp_lim;
  logic [49:0] wl_lim;
  logic        rate_ok;

  // Range and health
  assign healthy = stage_i.cur.power_ok && stage_i.cur.temp_ok && stage_i.cur.water_ok;
  assign in_range = !stage_i.cur.power[19]
                 && (stage_i.cur.power[18:0] <= cfg_i.power_max)
                 && (stage_i.cur.temperature >= cfg_i.temp_min)
                 && (stage_i.cur.temperature <= cfg_i.temp_max)
                 && !stage_i.cur.water_level[17]
                 && (stage_i.cur.water_level[16:0] <= WATER_ONE);

  // Time step, signed 33 bits without wrap
  assign dt     = {1'b0, stage_i.cur.timestamp_s} - {1'b0, stage_i.prev.timestamp_s};
  assign dt_bad = dt[32] || (dt == 33'd0);

  // Absolute changes
  assign pw_diff = {stage_i.cur.power[19], stage_i.cur.power}
                 - {stage_i.prev.power[19], stage_i.prev.power};
  assign tp_diff = {stage_i.cur.temperature[15], stage_i.cur.temperature}
                 - {stage_i.prev.temperature[15], stage_i.prev.temperature};
  assign wl_diff = {stage_i.cur.water_level[17], stage_i.cur.water_level}
                 - {stage_i.prev.water_level[17], stage_i.prev.water_level};
  assign pw_abs  = pw_diff[20] ? (21'd0 - pw_diff) : pw_diff;
  assign tp_abs  = tp_diff[16] ? (17'd0 - tp_diff) : tp_diff;
  assign wl_abs  = wl_diff[18] ? (19'd0 - wl_diff) : wl_diff;

  // Rate limit times step; dt is positive here so its low 32 bits are the step
  assign pw_lim = {32'd0, cfg_i.power_rate_max} * {20'd0, dt[31:0]};
  assign tp_lim = {32'd0, cfg_i.temp_rate_max} * {16'd0, dt[31:0]};
  assign wl_lim = {32'd0, cfg_i.water_rate_max} * {18'd0, dt[31:0]};

  assign rate_ok = ({31'd0, pw_abs} <= pw_lim)
                && ({31'd0, tp_abs} <= tp_lim)
                && ({31'd0, wl_abs} <= wl_lim);

  // Rating
  always_comb begin
    priority if (!in_range || !healthy) begin
      quality_o = Q_BAD;
    end else if (!stage_i.have_prev) begin
      quality_o = Q_GOOD;
    end else if (dt_bad) begin
      quality_o = Q_BAD;
    end else if (rate_ok) begin
      quality_o = Q_GOOD;
    end else begin
      quality_o = Q_SUSPECT;
    end
  end

endmodule

@@ rtl/telemetry_range_rate_gate_top.sv @@
// A request accepted into the input register has its result on the master side once
// the result register takes it (input register, then result register).
// Throughput: one frame per cycle unless m_axis_tready stalls the output; the input
// register feeds one stage of range checks and three parallel rate multiplies into the
// result register. Reset (rst_ni low, asynchronous): pipeline empty, no previous frame held,
// all limit registers at their widest settings.
module telemetry_range_rate_gate_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes
  input  logic                             cfg_we_i,
  input  logic [trrg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [trrg_pkg::CfgDataW-1:0]    cfg_data_i,
  // Frame input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // timestamp_s[31:0], power[51:32], temperature[67:52], water_level[85:68],
  // power_ok[86], temp_ok[87], water_ok[88], zero[95:89]
  input  logic [trrg_pkg::InDataW-1:0]     s_axis_tdata,
  // Rating output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // quality[1:0], forward[2], zero[7:3]
  output logic [trrg_pkg::OutDataW-1:0]    m_axis_tdata
);
  import trrg_pkg::*;

  cfg_t     cfg_q;
  frame_t   frame;
  stage_t   stage;
  logic     s1_valid;
  logic     advance;
  quality_e quality;
  logic     out_valid_q;
  quality_e out_q;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_max      <= 19'h7FFFF;
      cfg_q.temp_min       <= 16'sh8000;
      cfg_q.temp_max       <= 16'sh7FFF;
      cfg_q.power_rate_max <= 20'hFFFFF;
      cfg_q.temp_rate_max  <= 16'hFFFF;
      cfg_q.water_rate_max <= 18'h3FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POWER_MAX:      cfg_q.power_max      <= cfg_data_i[18:0];
        REG_TEMP_MIN:       cfg_q.temp_min       <= cfg_data_i[15:0];
        REG_TEMP_MAX:       cfg_q.temp_max       <= cfg_data_i[15:0];
        REG_POWER_RATE_MAX: cfg_q.power_rate_max <= cfg_data_i[19:0];
        REG_TEMP_RATE_MAX:  cfg_q.temp_rate_max  <= cfg_data_i[15:0];
        REG_WATER_RATE_MAX: cfg_q.water_rate_max <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // Unpack input payload
  assign frame.timestamp_s = s_axis_tdata[31:0];
  assign frame.power       = s_axis_tdata[51:32];
  assign frame.temperature = s_axis_tdata[67:52];
  assign frame.water_level = s_axis_tdata[85:68];
  assign frame.power_ok    = s_axis_tdata[86];
  assign frame.temp_ok     = s_axis_tdata[87];
  assign frame.water_ok    = s_axis_tdata[88];

  assign advance = s1_valid && (!out_valid_q || m_axis_tready);

  trrg_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .frame_i   (frame),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .stage_o   (stage)
  );

  trrg_check u_check (
    .stage_i   (stage),
    .cfg_i     (cfg_q),
    .quality_o (quality)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= quality;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, (out_q == Q_GOOD), out_q};

endmodule
